### rtl/xcfc_pkg.sv
// -----------------------------------------------------------------------------
// xcfc_pkg
// Shared types and constants for the XOR-checked frame checker.
// -----------------------------------------------------------------------------
package xcfc_pkg;

   localparam int unsigned MAX_MESSAGE = 32;   // bytes of a message that are checked
   localparam int unsigned STORE_DEPTH = 28;   // payload bytes held
   localparam int unsigned IDX_W       = 5;    // payload index / size width
   localparam int unsigned POS_W       = 6;    // byte position, saturating
   localparam logic [POS_W-1:0] POS_SAT = '1;

   localparam logic [7:0] HDR0 = 8'h06;
   localparam logic [7:0] HDR1 = 8'h85;

   typedef enum logic [2:0] {
      FS_GOOD          = 3'd0,
      FS_BAD_HEADER    = 3'd1,
      FS_SIZE_MISMATCH = 3'd2,
      FS_BAD_CHECKSUM  = 3'd3,
      FS_TOO_SHORT     = 3'd4
   } frame_status_type;

   typedef enum logic [1:0] {
      ST_RECV,
      ST_STATUS,
      ST_RELEASE
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept_en;     // receive side open
      logic load_status;   // load a status-only result
      logic load_entry;    // load the next stored payload byte
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic msg_end;        // final byte of a message transferred this cycle
      logic good_nonempty;  // that message was good with a non-empty payload
      logic out_free;       // result register can take a new result
      logic rel_last;       // current release entry is the final one
   } dp_status_type;

endpackage

### rtl/xor_checked_frame_checker.sv
// -----------------------------------------------------------------------------
// xor_checked_frame_checker
// Checks a framed message (header, length, payload, XOR checksum) and either
// releases the payload bytes in order or reports a single status result.
// -----------------------------------------------------------------------------
//  channel | direction | transfer carries
//  req_    | in        | tdata[7:0] rx_byte, tlast end_of_message
//  rsp_    | out       | tdata[7:0] payload_byte, tdata[12:8] payload_index,
//          |           | tlast last_of_run, tuser[2:0] frame_status
//  csr_    | in        | data[4:0] payload_size
//
// Bytes are taken one per cycle while receiving. After the final byte the
// receive side closes while results go out: payload_size results for a good
// non-empty frame, else one status result; one result per cycle unless stalled,
// through the result register. Reset is synchronous; the payload store is not
// cleared. A stalled result holds the result register and pauses the release.
// -----------------------------------------------------------------------------
module xor_checked_frame_checker
   import xcfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   input  logic        req_tlast,    // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [7:0] payload_byte, [12:8] payload_index
   output logic        rsp_tlast,    // last_of_run
   output logic [2:0]  rsp_tuser,    // [2:0] frame_status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data      // [4:0] payload_size
);

   ctrl_cmd_type      cmd;
   dp_status_type     status;
   logic [7:0]        out_byte;
   logic [IDX_W-1:0]  out_index;
   frame_status_type  out_status;

   xcfc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   xcfc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_valid),
      .csr_size   (csr_data),
      .in_xfer    (req_tvalid && req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .out_taken  (rsp_tvalid && rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_byte   (out_byte),
      .out_index  (out_index),
      .out_last   (rsp_tlast),
      .out_status (out_status)
   );

   assign req_tready = cmd.accept_en;
   assign csr_ready  = 1'b1;
   assign rsp_tdata  = {3'b000, out_index, out_byte};
   assign rsp_tuser  = out_status;

   // receive side closes straight after the final byte of a message
   a_close_after_end: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("receive side open after end of message");

   // a result is only loaded when the result register is free
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_status || cmd.load_entry) |-> status.out_free)
      else $error("result register overwritten");

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_status, cmd.load_entry}))
      else $error("two result loads at once");

   // a failure status is a single, final result with no payload
   a_fail_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != FS_GOOD)) |-> (rsp_tlast && (rsp_tdata == '0)))
      else $error("malformed status result");

endmodule

### rtl/xcfc_ctrl.sv
// -----------------------------------------------------------------------------
// xcfc_ctrl
// Sequencer: receive bytes, then emit a status result or release the payload.
// -----------------------------------------------------------------------------
module xcfc_ctrl
   import xcfc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RECV;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd.accept_en   = 1'b0;
      cmd.load_status = 1'b0;
      cmd.load_entry  = 1'b0;
      unique case (state_ff)
         ST_RECV: begin
            cmd.accept_en = 1'b1;
            if (status.msg_end) begin
               state_in = status.good_nonempty ? ST_RELEASE : ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (status.out_free) begin
               cmd.load_status = 1'b1;
               state_in        = ST_RECV;
            end
         end
         ST_RELEASE: begin
            if (status.out_free) begin
               cmd.load_entry = 1'b1;
               if (status.rel_last) begin
                  state_in = ST_RECV;
               end
            end
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

endmodule

### rtl/xcfc_dp.sv
// -----------------------------------------------------------------------------
// xcfc_dp
// Frame checks, payload store, release counter and result register.
// -----------------------------------------------------------------------------
module xcfc_dp
   import xcfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   input  logic                  csr_we,
   input  logic [IDX_W-1:0]      csr_size,
   input  logic                  in_xfer,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   input  logic                  out_taken,
   output logic                  out_valid,
   output logic [7:0]            out_byte,
   output logic [IDX_W-1:0]      out_index,
   output logic                  out_last,
   output frame_status_type      out_status
);

   logic [IDX_W-1:0]  size_ff;
   logic [POS_W-1:0]  pos_ff,  pos_in;
   logic [7:0]        run_ff,  run_in;
   logic              hdr_f_ff, hdr_f_in;
   logic              size_f_ff, size_f_in;
   logic              chk_f_ff, chk_f_in;
   logic              seen_ff, seen_in;
   frame_status_type  st_ff, st_in;
   logic [IDX_W-1:0]  rel_idx_ff;
   logic              valid_ff;

   logic [7:0]        store [STORE_DEPTH];
   logic              store_we;
   logic [IDX_W-1:0]  store_wa;
   logic [POS_W-1:0]  pay_off;
   logic [POS_W-1:0]  chk_pos;

   assign pay_off = pos_ff - POS_W'(3);
   assign chk_pos = POS_W'(size_ff) + POS_W'(3);

   always_comb begin
      pos_in    = (pos_ff != POS_SAT) ? pos_ff + POS_W'(1) : pos_ff;
      run_in    = run_ff;
      hdr_f_in  = hdr_f_ff;
      size_f_in = size_f_ff;
      chk_f_in  = chk_f_ff;
      seen_in   = seen_ff;
      store_we  = 1'b0;
      store_wa  = pay_off[IDX_W-1:0];
      if (({1'b0, pos_ff} < (POS_W+1)'(MAX_MESSAGE)) && !seen_ff) begin
         if (pos_ff == POS_W'(0)) begin
            if (in_byte != HDR0) hdr_f_in = 1'b1;
         end else if (pos_ff == POS_W'(1)) begin
            if (in_byte != HDR1) hdr_f_in = 1'b1;
         end else if (pos_ff == POS_W'(2)) begin
            if ((in_byte != 8'(size_ff)) || (size_ff > IDX_W'(STORE_DEPTH)))
               size_f_in = 1'b1;
            run_in = in_byte;
         end else if (!size_f_ff && (pos_ff < chk_pos)) begin
            run_in   = run_ff ^ in_byte;
            store_we = (pay_off < POS_W'(STORE_DEPTH));
         end else if (!size_f_ff && (pos_ff == chk_pos)) begin
            seen_in = 1'b1;
            if (in_byte != run_ff) chk_f_in = 1'b1;
         end
      end
      if (hdr_f_in)       st_in = FS_BAD_HEADER;
      else if (size_f_in) st_in = FS_SIZE_MISMATCH;
      else if (!seen_in)  st_in = FS_TOO_SHORT;
      else if (chk_f_in)  st_in = FS_BAD_CHECKSUM;
      else                st_in = FS_GOOD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= '0;
         pos_ff    <= '0;
         run_ff    <= '0;
         hdr_f_ff  <= 1'b0;
         size_f_ff <= 1'b0;
         chk_f_ff  <= 1'b0;
         seen_ff   <= 1'b0;
      end else begin
         if (csr_we) size_ff <= csr_size;
         if (in_xfer) begin
            if (in_last) begin
               pos_ff    <= '0;
               run_ff    <= '0;
               hdr_f_ff  <= 1'b0;
               size_f_ff <= 1'b0;
               chk_f_ff  <= 1'b0;
               seen_ff   <= 1'b0;
            end else begin
               pos_ff    <= pos_in;
               run_ff    <= run_in;
               hdr_f_ff  <= hdr_f_in;
               size_f_ff <= size_f_in;
               chk_f_ff  <= chk_f_in;
               seen_ff   <= seen_in;
            end
         end
      end
   end

   // payload store, registered read straight into the result register
   always_ff @(posedge clock) begin
      if (in_xfer && store_we) store[store_wa] <= in_byte;
   end

   always_ff @(posedge clock) begin
      if (in_xfer && in_last) st_ff <= st_in;
      if (in_xfer && in_last) begin
         rel_idx_ff <= '0;
      end else if (cmd.load_entry) begin
         rel_idx_ff <= rel_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_entry) begin
         out_byte   <= store[rel_idx_ff];
         out_index  <= rel_idx_ff;
         out_last   <= status.rel_last;
         out_status <= FS_GOOD;
      end else if (cmd.load_status) begin
         out_byte   <= '0;
         out_index  <= '0;
         out_last   <= 1'b1;
         out_status <= st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load_entry || cmd.load_status) begin
         valid_ff <= 1'b1;
      end else if (out_taken) begin
         valid_ff <= 1'b0;
      end
   end

   assign out_valid            = valid_ff;
   assign status.msg_end       = in_xfer && in_last;
   assign status.good_nonempty = (st_in == FS_GOOD) && (size_ff != '0);
   assign status.out_free      = !valid_ff || out_taken;
   assign status.rel_last      = ({1'b0, rel_idx_ff} + (IDX_W+1)'(1)) == {1'b0, size_ff};

endmodule

### tb/xor_checked_frame_checker_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// xor_checked_frame_checker_tb
// Feeds framed messages (header, length, payload, XOR checksum) with random
// stalls on both streams and checks every released payload byte or status
// against a cycle-free predictor of the frame checker.
// -----------------------------------------------------------------------------
module xor_checked_frame_checker_tb
   import xcfc_pkg::*;
();

   localparam int unsigned CALM_FROM = 200;   // no stalls on either side here
   localparam int unsigned CALM_TO   = 500;
   localparam int unsigned TAIL      = 8;     // quiet cycles after last result

   typedef struct {
      logic [7:0] data;
      logic       last;
   } rx_byte_type;

   typedef struct {
      logic [7:0]       data;
      logic [4:0]       index;
      logic             last;
      frame_status_type status;
   } frame_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] rx_byte
   logic        req_tlast  = 1'b0; // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [7:0] payload_byte, [12:8] payload_index
   logic        rsp_tlast;         // last_of_run
   logic [2:0]  rsp_tuser;         // [2:0] frame_status
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_data   = '0;   // [4:0] payload_size

   rx_byte_type      rx_backlog[$];
   frame_result_type awaited_results[$];
   logic [7:0]       msg[$];
   int unsigned      bytes_in_flight = 0;
   int unsigned      cycle_no        = 0;
   int unsigned      errors          = 0;

   // predictor state
   logic [4:0]  size_reg  = '0;
   int unsigned rx_pos    = 0;
   logic [7:0]  rx_sum    = '0;
   logic        hdr_bad   = 1'b0;
   logic        len_bad   = 1'b0;
   logic        sum_bad   = 1'b0;
   logic        sum_seen  = 1'b0;
   logic [7:0]  held_payload [STORE_DEPTH];

   xor_checked_frame_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) cycle_no <= cycle_no + 1;

   function automatic bit take_break();
      return (cycle_no < CALM_FROM || cycle_no > CALM_TO) && $urandom_range(99) < 33;
   endfunction

   function automatic void expect_status(frame_status_type st);
      awaited_results.push_back('{8'h00, 5'd0, 1'b1, st});
   endfunction

   // Track one accepted byte; on the final byte of a message queue its results.
   function automatic void absorb_byte(logic [7:0] b, logic eom);
      int unsigned sz;
      sz = size_reg;
      if (rx_pos < MAX_MESSAGE && !sum_seen) begin
         if (rx_pos == 0) begin
            if (b != HDR0) hdr_bad = 1'b1;
         end else if (rx_pos == 1) begin
            if (b != HDR1) hdr_bad = 1'b1;
         end else if (rx_pos == 2) begin
            if (b != sz || sz > STORE_DEPTH) len_bad = 1'b1;
            rx_sum = b;
         end else if (!len_bad && rx_pos < 3 + sz) begin
            rx_sum ^= b;
            if (rx_pos - 3 < STORE_DEPTH) held_payload[rx_pos - 3] = b;
         end else if (!len_bad && rx_pos == 3 + sz) begin
            sum_seen = 1'b1;
            if (b != rx_sum) sum_bad = 1'b1;
         end
      end
      if (rx_pos < 63) rx_pos++;
      if (!eom) return;

      if (hdr_bad) expect_status(FS_BAD_HEADER);
      else if (len_bad) expect_status(FS_SIZE_MISMATCH);
      else if (!sum_seen) expect_status(FS_TOO_SHORT);
      else if (sum_bad) expect_status(FS_BAD_CHECKSUM);
      else if (sz == 0) expect_status(FS_GOOD);
      else begin
         for (int unsigned i = 0; i < sz && i < STORE_DEPTH; i++)
            awaited_results.push_back('{held_payload[i], 5'(i), (i + 1 == sz), FS_GOOD});
      end
      rx_pos   = 0;
      rx_sum   = '0;
      hdr_bad  = 1'b0;
      len_bad  = 1'b0;
      sum_bad  = 1'b0;
      sum_seen = 1'b0;
   endfunction

   function automatic void compare_field(string what, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         errors++;
      end
   endfunction

   // request side: hold each byte until its transfer, then pick the next one
   always @(posedge clock) begin : req_driver
      rx_byte_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_byte(req_tdata, req_tlast);
            bytes_in_flight--;
         end
         if (!req_tvalid || req_tready) begin
            if (rx_backlog.size() != 0 && !take_break()) begin
               nxt = rx_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data;
               req_tlast  <= nxt.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      frame_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !take_break();
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got byte %02h status %0d",
                        $time, rsp_tdata[7:0], rsp_tuser);
               errors++;
            end else begin
               want = awaited_results.pop_front();
               compare_field("payload_byte", want.data, rsp_tdata[7:0]);
               compare_field("payload_index", want.index, rsp_tdata[12:8]);
               compare_field("last_of_run", want.last, rsp_tlast);
               compare_field("frame_status", want.status, rsp_tuser);
            end
         end
      end
   end

   function automatic void make_frame(int unsigned len_byte, int unsigned npay);
      logic [7:0] sum;
      logic [7:0] pb;
      msg.delete();
      sum = 8'(len_byte);
      msg.push_back(HDR0);
      msg.push_back(HDR1);
      msg.push_back(sum);
      repeat (npay) begin
         pb = 8'($urandom);
         sum ^= pb;
         msg.push_back(pb);
      end
      msg.push_back(sum);
   endfunction

   function automatic void send_msg();
      foreach (msg[i]) rx_backlog.push_back('{msg[i], i == msg.size() - 1});
      bytes_in_flight += msg.size();
      msg.delete();
   endfunction

   task automatic drain();
      do @(posedge clock); while (bytes_in_flight != 0 || awaited_results.size() != 0);
      repeat (TAIL) @(posedge clock);
   endtask

   task automatic write_size(logic [4:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_reg = value;
   endtask

   task automatic random_phase(int unsigned s);
      int unsigned queued;
      int unsigned kind;
      int unsigned k;
      int unsigned len;
      queued = 0;
      while (queued < 18) begin
         kind = $urandom_range(99);
         if (kind < 55) begin
            make_frame(s, s);
            if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom));
         end else if (kind < 65) begin
            make_frame(s, s);
            k = $urandom_range(msg.size() - 1);
            msg[k] ^= 8'(1 << $urandom_range(7));
         end else if (kind < 73) begin
            make_frame(s, s);
            k = $urandom_range(1, msg.size() - 1);
            while (msg.size() > k) void'(msg.pop_back());
         end else if (kind < 80) begin
            len = $urandom_range(31);
            if (len == s) len ^= 1;
            make_frame(len, s);
         end else if (kind < 86) begin
            make_frame(s, s);
            msg[msg.size() - 1] ^= 8'($urandom_range(1, 255));
         end else if (kind < 93) begin
            // runs past the checked message length
            make_frame(s, s);
            k = MAX_MESSAGE + $urandom_range(1, 6);
            while (msg.size() < k) msg.push_back(8'($urandom));
         end else begin
            msg.delete();
            repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom));
         end
         queued += msg.size();
         send_msg();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty payload with the register still at its reset value
      make_frame(0, 0);
      send_msg();
      drain();

      write_size(5'd1);
      msg = '{HDR0, HDR1, 8'h01, 8'hFF, 8'hFE};
      send_msg();
      msg = '{HDR0, HDR1, 8'h01, 8'h00, 8'h01, 8'h55};   // trailing byte ignored
      send_msg();
      msg = '{8'h00};
      send_msg();
      msg = '{HDR0, 8'h00};
      send_msg();
      msg = '{HDR0, HDR1, 8'h03, 8'h00};
      send_msg();
      msg = '{HDR0, HDR1, 8'h01};
      send_msg();
      msg = '{HDR0, HDR1, 8'h01, 8'h00, 8'h00};
      send_msg();
      drain();

      begin : phases
         int unsigned sizes[7];
         sizes = '{0, 28, 5, 31, 1, $urandom_range(2, 27), 17};
         foreach (sizes[i]) begin
            write_size(5'(sizes[i]));
            random_phase(sizes[i]);
            drain();
         end
      end

      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #200000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

### filelist.f
rtl/xcfc_pkg.sv
rtl/xcfc_ctrl.sv
rtl/xcfc_dp.sv
rtl/xor_checked_frame_checker.sv
tb/xor_checked_frame_checker_tb.sv
